[design/cnsu_pkg.sv]
// ----------------------------------------------------------------------------
// cnsu_pkg
// Shared types, register codes, reset values and saturation helpers for the
// cloth node spring update pipeline.
// ----------------------------------------------------------------------------
package cnsu_pkg;

    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS   = 3'd0,
        CFG_REST_LENGTH = 3'd1,
        CFG_GRAVITY     = 3'd2,
        CFG_DAMPING     = 3'd3,
        CFG_SPEED_LIMIT = 3'd4
    } cfg_index_t;

    // Live configuration, handed to the spring and velocity units
    typedef struct packed {
        logic [30:0] stiffness;
        logic [30:0] rest_length;
        logic [30:0] gravity;
        logic [20:0] damping;
        logic [30:0] speed_limit;
    } cfg_t;

    localparam logic [30:0] RST_STIFFNESS   = 31'd314573;
    localparam logic [30:0] RST_REST_LENGTH = 31'd10485760;
    localparam logic [30:0] RST_GRAVITY     = 31'd1049;
    localparam logic [20:0] RST_DAMPING     = 21'd6291;
    localparam logic [30:0] RST_SPEED_LIMIT = 31'd5242880;

    localparam logic [30:0] MAX_POS31 = 31'h7fffffff;

    // Saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [35:0] v);
        logic signed [35:0] hi;
        logic signed [35:0] lo;
        hi = 36'sd2147483647;
        lo = -36'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return $signed(v[31:0]);
    endfunction

    // Magnitude of a signed 32-bit value, exact for the most negative code
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

endpackage

[design/cnsu_isqrt.sv]
// ----------------------------------------------------------------------------
// cnsu_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// Carries a sideband word alongside each item.
// ----------------------------------------------------------------------------
module cnsu_isqrt #(
    parameter int IN_W   = 64,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      radicand,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int OUT_W  = IN_W / 2;
    localparam int REM_W  = OUT_W + 2;
    localparam int STAGES = OUT_W;

    logic              valid_reg [STAGES];
    logic [IN_W-1:0]   rad_reg   [STAGES];
    logic [IN_W-1:0]   rad_next  [STAGES];
    logic [REM_W-1:0]  rem_reg   [STAGES];
    logic [REM_W-1:0]  rem_next  [STAGES];
    logic [OUT_W-1:0]  root_reg  [STAGES];
    logic [OUT_W-1:0]  root_next [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];

    // Decide one root bit per stage
    always_comb
    begin : stage_logic
        logic [IN_W-1:0]  rad_src;
        logic [REM_W-1:0] rem_src;
        logic [REM_W-1:0] rem_try;
        logic [REM_W-1:0] trial;
        logic [OUT_W-1:0] root_src;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                rad_src  = radicand;
                rem_src  = '0;
                root_src = '0;
            end
            else
            begin
                rad_src  = rad_reg[s-1];
                rem_src  = rem_reg[s-1];
                root_src = root_reg[s-1];
            end
            rem_try = {rem_src[REM_W-3:0], rad_src[IN_W-1 -: 2]};
            trial   = {root_src, 2'b01};
            if (rem_try >= trial)
            begin
                rem_next[s]  = rem_try - trial;
                root_next[s] = {root_src[OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_try;
                root_next[s] = {root_src[OUT_W-2:0], 1'b0};
            end
            rad_next[s] = {rad_src[IN_W-3:0], 2'b00};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            rad_reg[s]  <= rad_next[s];
            rem_reg[s]  <= rem_next[s];
            root_reg[s] <= root_next[s];
            side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign root      = root_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

[design/cnsu_div.sv]
// ----------------------------------------------------------------------------
// cnsu_div
// Pipelined restoring divider, one quotient bit per stage. The quotient must
// fit in QUO_W bits; otherwise the result is meaningless.
// ----------------------------------------------------------------------------
module cnsu_div #(
    parameter int NUM_W  = 52,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 21,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  numerator,
    input  logic [DEN_W-1:0]  denominator,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quotient,
    output logic [SIDE_W-1:0] side_out
);

    localparam int STAGES = QUO_W;

    logic              valid_reg [STAGES];
    logic [QUO_W-1:0]  num_reg   [STAGES];
    logic [QUO_W-1:0]  num_next  [STAGES];
    logic [DEN_W-1:0]  den_reg   [STAGES];
    logic [DEN_W-1:0]  rem_reg   [STAGES];
    logic [DEN_W-1:0]  rem_next  [STAGES];
    logic [QUO_W-1:0]  quo_reg   [STAGES];
    logic [QUO_W-1:0]  quo_next  [STAGES];
    logic [SIDE_W-1:0] side_reg  [STAGES];

    // Subtract or pass per quotient bit
    always_comb
    begin : stage_logic
        logic [QUO_W-1:0] num_src;
        logic [DEN_W-1:0] den_src;
        logic [DEN_W-1:0] rem_src;
        logic [QUO_W-1:0] quo_src;
        logic [DEN_W:0]   rem_try;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                num_src = numerator[QUO_W-1:0];
                den_src = denominator;
                rem_src = DEN_W'(numerator[NUM_W-1:QUO_W]);
                quo_src = '0;
            end
            else
            begin
                num_src = num_reg[s-1];
                den_src = den_reg[s-1];
                rem_src = rem_reg[s-1];
                quo_src = quo_reg[s-1];
            end
            rem_try = {rem_src, num_src[QUO_W-1]};
            if (rem_try >= {1'b0, den_src})
            begin
                rem_next[s] = DEN_W'(rem_try - {1'b0, den_src});
                quo_next[s] = {quo_src[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = rem_try[DEN_W-1:0];
                quo_next[s] = {quo_src[QUO_W-2:0], 1'b0};
            end
            num_next[s] = {num_src[QUO_W-2:0], 1'b0};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            num_reg[s]  <= num_next[s];
            rem_reg[s]  <= rem_next[s];
            quo_reg[s]  <= quo_next[s];
            den_reg[s]  <= (s == 0) ? denominator : den_reg[(s == 0) ? 0 : s-1];
            side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s-1];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = quo_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

[design/cnsu_spring.sv]
// ----------------------------------------------------------------------------
// cnsu_spring
// Hooke spring force of one neighbour on the node: offset, distance by
// square root, unit vector by division, force magnitude and projection.
// ----------------------------------------------------------------------------
module cnsu_spring #(
    parameter int FRAC_BITS = 20,
    parameter int SIDE_W    = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                enable,
    input  logic signed [31:0]  node_x,
    input  logic signed [31:0]  node_y,
    input  logic signed [31:0]  nbr_x,
    input  logic signed [31:0]  nbr_y,
    input  cnsu_pkg::cfg_t      cfg,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output logic signed [32:0]  force_x,
    output logic signed [32:0]  force_y,
    output logic [SIDE_W-1:0]   side_out
);

    import cnsu_pkg::*;

    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int NUM_W  = FRAC_BITS + 32;
    localparam int CX_W   = FRAC_BITS + 32;
    localparam int SQ_SW  = 32 + 32 + 3 + SIDE_W;
    localparam int DX_SW  = 32 + 3 + SIDE_W;

    // Offset stage
    logic signed [31:0] dx_sat, dy_sat;
    logic               d_valid_reg;
    logic [31:0]        d_adx_reg, d_ady_reg;
    logic               d_sx_reg, d_sy_reg, d_en_reg;
    logic [SIDE_W-1:0]  d_side_reg;

    // Offset runs from the neighbour to the node
    assign dx_sat = sat_s32(36'(node_x) - 36'(nbr_x));
    assign dy_sat = sat_s32(36'(node_y) - 36'(nbr_y));

    // Square stage
    logic               q_valid_reg;
    logic [63:0]        q_sqx_reg, q_sqy_reg;
    logic [31:0]        q_adx_reg, q_ady_reg;
    logic               q_sx_reg, q_sy_reg, q_en_reg;
    logic [SIDE_W-1:0]  q_side_reg;

    // Sum stage
    logic               s_valid_reg;
    logic [63:0]        s_sum_reg;
    logic [SQ_SW-1:0]   s_pack_reg;

    // Square root
    logic               r_valid;
    logic [31:0]        r_dist;
    logic [SQ_SW-1:0]   r_pack;
    logic [31:0]        r_adx, r_ady;
    logic               r_sx, r_sy, r_en;
    logic [SIDE_W-1:0]  r_side;

    // Stretch stage
    logic signed [32:0] stretch;
    logic               a_valid_reg;
    logic [31:0]        a_dist_reg, a_absnum_reg, a_adx_reg, a_ady_reg;
    logic               a_pos_reg, a_en_reg, a_sx_reg, a_sy_reg;
    logic [SIDE_W-1:0]  a_side_reg;

    // Unit vector
    logic               ux_valid;
    logic [QUO_W-1:0]   ux_quo, uy_quo;
    logic [DX_SW-1:0]   ux_pack;
    logic               uy_sy;
    logic [31:0]        u_absnum;
    logic               u_pos, u_en, u_sx;
    logic [SIDE_W-1:0]  u_side;

    // Magnitude and projection stages
    logic               b_valid_reg, c_valid_reg, e_valid_reg;
    logic               dd_valid_reg;
    logic [62:0]        b_prod_reg;
    logic [QUO_W-1:0]   b_ux_reg, b_uy_reg, c_ux_reg, c_uy_reg;
    logic               b_pos_reg, b_en_reg, b_sx_reg, b_sy_reg;
    logic               c_pos_reg, c_en_reg, c_sx_reg, c_sy_reg;
    logic               dd_pos_reg, dd_en_reg, dd_sx_reg, dd_sy_reg;
    logic [SIDE_W-1:0]  b_side_reg, c_side_reg, dd_side_reg, e_side_reg;
    logic [62:0]        prod_sh;
    logic [30:0]        mag_next, c_mag_reg;
    logic [CX_W-1:0]    dd_cx_reg, dd_cy_reg;
    logic [30:0]        comp_x, comp_y;
    logic signed [32:0] term_x_next, term_y_next, e_fx_reg, e_fy_reg;

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg  <= 1'b0;
            q_valid_reg  <= 1'b0;
            s_valid_reg  <= 1'b0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            dd_valid_reg <= 1'b0;
            e_valid_reg  <= 1'b0;
        end
        else
        begin
            d_valid_reg  <= in_valid;
            q_valid_reg  <= d_valid_reg;
            s_valid_reg  <= q_valid_reg;
            a_valid_reg  <= r_valid;
            b_valid_reg  <= ux_valid;
            c_valid_reg  <= b_valid_reg;
            dd_valid_reg <= c_valid_reg;
            e_valid_reg  <= dd_valid_reg;
        end
    end

    // Offset, squares and sum of squares
    always_ff @(posedge clk)
    begin
        d_adx_reg  <= abs32(dx_sat);
        d_ady_reg  <= abs32(dy_sat);
        d_sx_reg   <= dx_sat[31];
        d_sy_reg   <= dy_sat[31];
        d_en_reg   <= enable;
        d_side_reg <= side_in;

        q_sqx_reg  <= 64'(d_adx_reg) * 64'(d_adx_reg);
        q_sqy_reg  <= 64'(d_ady_reg) * 64'(d_ady_reg);
        q_adx_reg  <= d_adx_reg;
        q_ady_reg  <= d_ady_reg;
        q_sx_reg   <= d_sx_reg;
        q_sy_reg   <= d_sy_reg;
        q_en_reg   <= d_en_reg;
        q_side_reg <= d_side_reg;

        s_sum_reg  <= q_sqx_reg + q_sqy_reg;
        s_pack_reg <= {q_adx_reg, q_ady_reg, q_sx_reg, q_sy_reg, q_en_reg, q_side_reg};
    end

    cnsu_isqrt #(
        .IN_W   (64),
        .SIDE_W (SQ_SW)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_valid_reg),
        .radicand  (s_sum_reg),
        .side_in   (s_pack_reg),
        .out_valid (r_valid),
        .root      (r_dist),
        .side_out  (r_pack)
    );

    assign {r_adx, r_ady, r_sx, r_sy, r_en, r_side} = r_pack;

    // Stretch against the rest length; drop a coincident neighbour
    assign stretch = $signed({2'b00, cfg.rest_length}) - $signed({1'b0, r_dist});

    always_ff @(posedge clk)
    begin
        a_dist_reg   <= r_dist;
        a_absnum_reg <= stretch[32] ? 32'(-stretch) : stretch[31:0];
        a_pos_reg    <= !stretch[32];
        a_en_reg     <= r_en && (r_dist != 32'd0);
        a_adx_reg    <= r_adx;
        a_ady_reg    <= r_ady;
        a_sx_reg     <= r_sx;
        a_sy_reg     <= r_sy;
        a_side_reg   <= r_side;
    end

    cnsu_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (32),
        .QUO_W  (QUO_W),
        .SIDE_W (DX_SW)
    ) u_unit_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (a_valid_reg),
        .numerator   ({a_adx_reg, {FRAC_BITS{1'b0}}}),
        .denominator (a_dist_reg),
        .side_in     ({a_absnum_reg, a_pos_reg, a_en_reg, a_sx_reg, a_side_reg}),
        .out_valid   (ux_valid),
        .quotient    (ux_quo),
        .side_out    (ux_pack)
    );

    cnsu_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (32),
        .QUO_W  (QUO_W),
        .SIDE_W (1)
    ) u_unit_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (a_valid_reg),
        .numerator   ({a_ady_reg, {FRAC_BITS{1'b0}}}),
        .denominator (a_dist_reg),
        .side_in     (a_sy_reg),
        .out_valid   (),
        .quotient    (uy_quo),
        .side_out    (uy_sy)
    );

    assign {u_absnum, u_pos, u_en, u_sx, u_side} = ux_pack;

    // Force magnitude, saturated to 31 bits
    assign prod_sh  = b_prod_reg >> FRAC_BITS;
    assign mag_next = (prod_sh > 63'(MAX_POS31)) ? MAX_POS31 : prod_sh[30:0];

    // Project onto the offset and apply direction
    assign comp_x = dd_cx_reg[FRAC_BITS+30:FRAC_BITS];
    assign comp_y = dd_cy_reg[FRAC_BITS+30:FRAC_BITS];

    always_comb
    begin
        term_x_next = '0;
        term_y_next = '0;
        if (dd_en_reg)
        begin
            term_x_next = (dd_sx_reg == dd_pos_reg) ? -$signed({2'b00, comp_x})
                                                    : $signed({2'b00, comp_x});
            term_y_next = (dd_sy_reg == dd_pos_reg) ? -$signed({2'b00, comp_y})
                                                    : $signed({2'b00, comp_y});
        end
    end

    always_ff @(posedge clk)
    begin
        b_prod_reg  <= 63'(u_absnum) * 63'(cfg.stiffness);
        b_ux_reg    <= ux_quo;
        b_uy_reg    <= uy_quo;
        b_pos_reg   <= u_pos;
        b_en_reg    <= u_en;
        b_sx_reg    <= u_sx;
        b_sy_reg    <= uy_sy;
        b_side_reg  <= u_side;

        c_mag_reg   <= mag_next;
        c_ux_reg    <= b_ux_reg;
        c_uy_reg    <= b_uy_reg;
        c_pos_reg   <= b_pos_reg;
        c_en_reg    <= b_en_reg;
        c_sx_reg    <= b_sx_reg;
        c_sy_reg    <= b_sy_reg;
        c_side_reg  <= b_side_reg;

        dd_cx_reg   <= CX_W'(c_mag_reg) * CX_W'(c_ux_reg);
        dd_cy_reg   <= CX_W'(c_mag_reg) * CX_W'(c_uy_reg);
        dd_pos_reg  <= c_pos_reg;
        dd_en_reg   <= c_en_reg;
        dd_sx_reg   <= c_sx_reg;
        dd_sy_reg   <= c_sy_reg;
        dd_side_reg <= c_side_reg;

        e_fx_reg    <= term_x_next;
        e_fy_reg    <= term_y_next;
        e_side_reg  <= dd_side_reg;
    end

    assign out_valid = e_valid_reg;
    assign force_x   = e_fx_reg;
    assign force_y   = e_fy_reg;
    assign side_out  = e_side_reg;

endmodule

[design/cnsu_vel.sv]
// ----------------------------------------------------------------------------
// cnsu_vel
// Velocity and position update: sum forces, add gravity, integrate, clamp
// to the speed limit, damp and advance the position.
// ----------------------------------------------------------------------------
module cnsu_vel #(
    parameter int FRAC_BITS = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [32:0]  force_x [4],
    input  logic signed [32:0]  force_y [4],
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  cnsu_pkg::cfg_t      cfg,
    output logic                out_valid,
    output logic signed [31:0]  new_pos_x,
    output logic signed [31:0]  new_pos_y,
    output logic signed [31:0]  new_vel_x,
    output logic signed [31:0]  new_vel_y,
    output logic                speed_clamped
);

    import cnsu_pkg::*;

    localparam int KEEP_W = FRAC_BITS + 1;
    localparam int PM_W   = FRAC_BITS + 33;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    // Constants derived from configuration
    logic [61:0]        lim2_reg;
    logic [KEEP_W-1:0]  keep_reg;
    logic [31:0]        damp_wide;

    assign damp_wide = 32'(cfg.damping);

    always_ff @(posedge clk)
    begin
        lim2_reg <= 62'(cfg.speed_limit) * 62'(cfg.speed_limit);
        keep_reg <= KEEP_W'(ONE - ((damp_wide > ONE) ? ONE : damp_wide));
    end

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic               s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic               s9_valid_reg, s10_valid_reg;

    logic signed [35:0] s1_fx_reg, s1_fy_reg;
    logic signed [31:0] s1_px_reg, s1_py_reg, s1_vx_reg, s1_vy_reg;
    logic signed [31:0] s2_fx_reg, s2_fy_reg;
    logic signed [31:0] s2_px_reg, s2_py_reg, s2_vx_reg, s2_vy_reg;
    logic signed [31:0] s3_vx_reg, s3_vy_reg, s3_px_reg, s3_py_reg;
    logic [63:0]        s4_sqx_reg, s4_sqy_reg;
    logic signed [31:0] s4_vx_reg, s4_vy_reg, s4_px_reg, s4_py_reg;
    logic [63:0]        s5_mag2_reg;
    logic               s5_clamped_reg;
    logic signed [31:0] s5_vx_reg, s5_vy_reg, s5_px_reg, s5_py_reg;

    logic               r_valid;
    logic [31:0]        r_mag;
    logic [128:0]       r_pack;
    logic signed [31:0] r_px, r_py, r_vx, r_vy;
    logic               r_clamped;

    logic [62:0]        s6_prodx_reg, s6_prody_reg;
    logic [31:0]        s6_mag_reg;
    logic signed [31:0] s6_px_reg, s6_py_reg, s6_vx_reg, s6_vy_reg;
    logic               s6_clamped_reg;

    logic               qx_valid;
    logic [30:0]        qx, qy;
    logic [64:0]        qx_pack;
    logic [63:0]        qy_pack;
    logic signed [31:0] q_px, q_py, q_vx, q_vy;
    logic               q_clamped;
    logic signed [31:0] vc_x, vc_y;

    logic signed [31:0] s7_vx_reg, s7_vy_reg, s7_px_reg, s7_py_reg;
    logic               s7_clamped_reg;
    logic [PM_W-1:0]    s8_pmx_reg, s8_pmy_reg;
    logic               s8_sx_reg, s8_sy_reg, s8_clamped_reg;
    logic signed [31:0] s8_px_reg, s8_py_reg;
    logic [31:0]        damp_x, damp_y;
    logic signed [31:0] s9_vx_reg, s9_vy_reg, s9_px_reg, s9_py_reg;
    logic               s9_clamped_reg;
    logic signed [31:0] s10_px_reg, s10_py_reg, s10_vx_reg, s10_vy_reg;
    logic               s10_clamped_reg;

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= r_valid;
            s7_valid_reg  <= qx_valid;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
        end
    end

    // Sum forces, integrate, square the speed
    always_ff @(posedge clk)
    begin
        s1_fx_reg <= 36'(force_x[0]) + 36'(force_x[1]) + 36'(force_x[2]) + 36'(force_x[3]);
        s1_fy_reg <= 36'(force_y[0]) + 36'(force_y[1]) + 36'(force_y[2]) + 36'(force_y[3])
                     - $signed({5'b00000, cfg.gravity});
        s1_px_reg <= pos_x;
        s1_py_reg <= pos_y;
        s1_vx_reg <= vel_x;
        s1_vy_reg <= vel_y;

        s2_fx_reg <= sat_s32(s1_fx_reg);
        s2_fy_reg <= sat_s32(s1_fy_reg);
        s2_px_reg <= s1_px_reg;
        s2_py_reg <= s1_py_reg;
        s2_vx_reg <= s1_vx_reg;
        s2_vy_reg <= s1_vy_reg;

        s3_vx_reg <= sat_s32(36'(s2_vx_reg) + 36'(s2_fx_reg));
        s3_vy_reg <= sat_s32(36'(s2_vy_reg) + 36'(s2_fy_reg));
        s3_px_reg <= s2_px_reg;
        s3_py_reg <= s2_py_reg;

        s4_sqx_reg <= 64'(abs32(s3_vx_reg)) * 64'(abs32(s3_vx_reg));
        s4_sqy_reg <= 64'(abs32(s3_vy_reg)) * 64'(abs32(s3_vy_reg));
        s4_vx_reg  <= s3_vx_reg;
        s4_vy_reg  <= s3_vy_reg;
        s4_px_reg  <= s3_px_reg;
        s4_py_reg  <= s3_py_reg;

        s5_mag2_reg    <= s4_sqx_reg + s4_sqy_reg;
        s5_clamped_reg <= (s4_sqx_reg + s4_sqy_reg) > 64'(lim2_reg);
        s5_vx_reg      <= s4_vx_reg;
        s5_vy_reg      <= s4_vy_reg;
        s5_px_reg      <= s4_px_reg;
        s5_py_reg      <= s4_py_reg;
    end

    cnsu_isqrt #(
        .IN_W   (64),
        .SIDE_W (129)
    ) u_speed (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s5_valid_reg),
        .radicand  (s5_mag2_reg),
        .side_in   ({s5_px_reg, s5_py_reg, s5_vx_reg, s5_vy_reg, s5_clamped_reg}),
        .out_valid (r_valid),
        .root      (r_mag),
        .side_out  (r_pack)
    );

    assign {r_px, r_py, r_vx, r_vy, r_clamped} = r_pack;

    // Scale numerators for the clamp
    always_ff @(posedge clk)
    begin
        s6_prodx_reg   <= 63'(abs32(r_vx)) * 63'(cfg.speed_limit);
        s6_prody_reg   <= 63'(abs32(r_vy)) * 63'(cfg.speed_limit);
        s6_mag_reg     <= r_mag;
        s6_px_reg      <= r_px;
        s6_py_reg      <= r_py;
        s6_vx_reg      <= r_vx;
        s6_vy_reg      <= r_vy;
        s6_clamped_reg <= r_clamped;
    end

    cnsu_div #(
        .NUM_W  (63),
        .DEN_W  (32),
        .QUO_W  (31),
        .SIDE_W (65)
    ) u_clamp_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s6_valid_reg),
        .numerator   (s6_prodx_reg),
        .denominator (s6_mag_reg),
        .side_in     ({s6_px_reg, s6_vx_reg, s6_clamped_reg}),
        .out_valid   (qx_valid),
        .quotient    (qx),
        .side_out    (qx_pack)
    );

    cnsu_div #(
        .NUM_W  (63),
        .DEN_W  (32),
        .QUO_W  (31),
        .SIDE_W (64)
    ) u_clamp_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s6_valid_reg),
        .numerator   (s6_prody_reg),
        .denominator (s6_mag_reg),
        .side_in     ({s6_py_reg, s6_vy_reg}),
        .out_valid   (),
        .quotient    (qy),
        .side_out    (qy_pack)
    );

    assign {q_px, q_vx, q_clamped} = qx_pack;
    assign {q_py, q_vy}            = qy_pack;

    // Select clamped or raw velocity, sign toward zero
    assign vc_x = q_clamped ? (q_vx[31] ? -$signed({1'b0, qx}) : $signed({1'b0, qx})) : q_vx;
    assign vc_y = q_clamped ? (q_vy[31] ? -$signed({1'b0, qy}) : $signed({1'b0, qy})) : q_vy;

    assign damp_x = s8_pmx_reg[FRAC_BITS+31:FRAC_BITS];
    assign damp_y = s8_pmy_reg[FRAC_BITS+31:FRAC_BITS];

    // Damp and advance position
    always_ff @(posedge clk)
    begin
        s7_vx_reg      <= vc_x;
        s7_vy_reg      <= vc_y;
        s7_px_reg      <= q_px;
        s7_py_reg      <= q_py;
        s7_clamped_reg <= q_clamped;

        s8_pmx_reg     <= PM_W'(abs32(s7_vx_reg)) * PM_W'(keep_reg);
        s8_pmy_reg     <= PM_W'(abs32(s7_vy_reg)) * PM_W'(keep_reg);
        s8_sx_reg      <= s7_vx_reg[31];
        s8_sy_reg      <= s7_vy_reg[31];
        s8_px_reg      <= s7_px_reg;
        s8_py_reg      <= s7_py_reg;
        s8_clamped_reg <= s7_clamped_reg;

        s9_vx_reg      <= s8_sx_reg ? -$signed(damp_x) : $signed(damp_x);
        s9_vy_reg      <= s8_sy_reg ? -$signed(damp_y) : $signed(damp_y);
        s9_px_reg      <= s8_px_reg;
        s9_py_reg      <= s8_py_reg;
        s9_clamped_reg <= s8_clamped_reg;

        s10_px_reg      <= s9_px_reg + s9_vx_reg;
        s10_py_reg      <= s9_py_reg + s9_vy_reg;
        s10_vx_reg      <= s9_vx_reg;
        s10_vy_reg      <= s9_vy_reg;
        s10_clamped_reg <= s9_clamped_reg;
    end

    assign out_valid     = s10_valid_reg;
    assign new_pos_x     = s10_px_reg;
    assign new_pos_y     = s10_py_reg;
    assign new_vel_x     = s10_vx_reg;
    assign new_vel_y     = s10_vy_reg;
    assign speed_clamped = s10_clamped_reg;

endmodule

[design/cloth_node_spring_update.sv]
// ----------------------------------------------------------------------------
// cloth_node_spring_update
// One explicit Euler step of a mass-spring cloth node in signed fixed point.
// ----------------------------------------------------------------------------
// A node command is taken on any cycle that start is high; busy stays low, so
// one node can be issued every clock. Each command gives exactly one result,
// shown for a single cycle with done high. The path runs through two 32-stage
// square root pipelines (spring length and speed) and the restoring dividers
// for the unit vector and the speed clamp. The receiver cannot stall the block;
// results must be taken when done is high. Write configuration only when no
// command is in flight.
// ----------------------------------------------------------------------------
module cloth_node_spring_update #(
    parameter int FRAC_BITS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [31:0]                 pos_x,
    input  logic signed [31:0]                 pos_y,
    input  logic signed [31:0]                 vel_x,
    input  logic signed [31:0]                 vel_y,
    input  logic signed [31:0]                 first_x,
    input  logic signed [31:0]                 first_y,
    input  logic signed [31:0]                 second_x,
    input  logic signed [31:0]                 second_y,
    input  logic signed [31:0]                 third_x,
    input  logic signed [31:0]                 third_y,
    input  logic signed [31:0]                 fourth_x,
    input  logic signed [31:0]                 fourth_y,
    output logic                               done,
    output logic signed [31:0]                 new_pos_x,
    output logic signed [31:0]                 new_pos_y,
    output logic signed [31:0]                 new_vel_x,
    output logic signed [31:0]                 new_vel_y,
    output logic                               speed_clamped,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cnsu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cnsu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import cnsu_pkg::*;

    cfg_t cfg_reg, cfg_next;

    // Decode configuration transactions
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_STIFFNESS:   cfg_next.stiffness   = cfg_data[30:0];
                CFG_REST_LENGTH: cfg_next.rest_length = cfg_data[30:0];
                CFG_GRAVITY:     cfg_next.gravity     = cfg_data[30:0];
                CFG_DAMPING:     cfg_next.damping     = cfg_data[20:0];
                CFG_SPEED_LIMIT: cfg_next.speed_limit = cfg_data[30:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stiffness   <= RST_STIFFNESS;
            cfg_reg.rest_length <= RST_REST_LENGTH;
            cfg_reg.gravity     <= RST_GRAVITY;
            cfg_reg.damping     <= RST_DAMPING;
            cfg_reg.speed_limit <= RST_SPEED_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    logic               accept;
    logic               third_on, fourth_on;
    logic               spring_valid;
    logic [127:0]       node_pack;
    logic signed [31:0] sp_px, sp_py, sp_vx, sp_vy;
    logic signed [32:0] fx [4];
    logic signed [32:0] fy [4];

    assign accept = start && !busy;

    // A missing neighbour shares a coordinate with the node
    assign third_on  = (third_x != pos_x) && (third_y != pos_y);
    assign fourth_on = (fourth_x != pos_x) && (fourth_y != pos_y);

    cnsu_spring #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (128)
    ) u_spring0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .enable    (1'b1),
        .node_x    (pos_x),
        .node_y    (pos_y),
        .nbr_x     (first_x),
        .nbr_y     (first_y),
        .cfg       (cfg_reg),
        .side_in   ({pos_x, pos_y, vel_x, vel_y}),
        .out_valid (spring_valid),
        .force_x   (fx[0]),
        .force_y   (fy[0]),
        .side_out  (node_pack)
    );

    cnsu_spring #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_spring1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .enable    (1'b1),
        .node_x    (pos_x),
        .node_y    (pos_y),
        .nbr_x     (second_x),
        .nbr_y     (second_y),
        .cfg       (cfg_reg),
        .side_in   (1'b0),
        .out_valid (),
        .force_x   (fx[1]),
        .force_y   (fy[1]),
        .side_out  ()
    );

    cnsu_spring #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_spring2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .enable    (third_on),
        .node_x    (pos_x),
        .node_y    (pos_y),
        .nbr_x     (third_x),
        .nbr_y     (third_y),
        .cfg       (cfg_reg),
        .side_in   (1'b0),
        .out_valid (),
        .force_x   (fx[2]),
        .force_y   (fy[2]),
        .side_out  ()
    );

    cnsu_spring #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_spring3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .enable    (fourth_on),
        .node_x    (pos_x),
        .node_y    (pos_y),
        .nbr_x     (fourth_x),
        .nbr_y     (fourth_y),
        .cfg       (cfg_reg),
        .side_in   (1'b0),
        .out_valid (),
        .force_x   (fx[3]),
        .force_y   (fy[3]),
        .side_out  ()
    );

    assign {sp_px, sp_py, sp_vx, sp_vy} = node_pack;

    cnsu_vel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_vel (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (spring_valid),
        .force_x       (fx),
        .force_y       (fy),
        .pos_x         (sp_px),
        .pos_y         (sp_py),
        .vel_x         (sp_vx),
        .vel_y         (sp_vy),
        .cfg           (cfg_reg),
        .out_valid     (done),
        .new_pos_x     (new_pos_x),
        .new_pos_y     (new_pos_y),
        .new_vel_x     (new_vel_x),
        .new_vel_y     (new_vel_y),
        .speed_clamped (speed_clamped)
    );

endmodule

[verif/tb_cloth_node_spring_update.sv]
// ----------------------------------------------------------------------------
// tb_cloth_node_spring_update
// Self-checking bench for the cloth node spring update pipeline. Drives node
// commands with random gaps and checks every result against a bit-exact
// fixed-point predictor under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_cloth_node_spring_update;
    import cnsu_pkg::*;

    localparam int FRAC  = 20;
    localparam int DRAIN = FRAC + 130;

    typedef struct {
        logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
        logic signed [31:0] first_x, first_y, second_x, second_y;
        logic signed [31:0] third_x, third_y, fourth_x, fourth_y;
    } node_t;

    typedef struct {
        logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
        logic               speed_clamped;
    } step_t;

    // Predicts node updates and holds the expected results in order
    class step_scoreboard;
        longint unsigned stiff, rest, grav, damp, limit;
        step_t           pending[$];
        int              fails;

        function void reset_regs();
            stiff = 314573; rest = 10485760; grav = 1049; damp = 6291; limit = 5242880;
            fails = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [31:0] data);
            case (idx)
                CFG_STIFFNESS:   stiff = data[30:0];
                CFG_REST_LENGTH: rest  = data[30:0];
                CFG_GRAVITY:     grav  = data[30:0];
                CFG_DAMPING:     damp  = data[20:0];
                CFG_SPEED_LIMIT: limit = data[30:0];
                default: ;
            endcase
        endfunction

        function longint sat(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint unsigned mag_of(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // Hooke force of one neighbour, accumulated into fx/fy
        function void spring(longint rx, longint ry, longint nx, longint ny,
                             inout longint fx, inout longint fy);
            longint          dx, dy, num;
            longint unsigned adx, ady, span_len, mag, ux, uy, cx, cy;
            bit              pushes;
            dx = sat(rx - nx);
            dy = sat(ry - ny);
            adx = mag_of(dx);
            ady = mag_of(dy);
            span_len = root(adx * adx + ady * ady);
            if (span_len == 0)
                return;
            num = longint'(rest) - longint'(span_len);
            mag = (mag_of(num) * stiff) >> FRAC;
            if (mag > 64'h7fffffff)
                mag = 64'h7fffffff;
            ux = (adx << FRAC) / span_len;
            uy = (ady << FRAC) / span_len;
            cx = (mag * ux) >> FRAC;
            cy = (mag * uy) >> FRAC;
            pushes = (num >= 0);
            fx += ((dx < 0) == pushes) ? -longint'(cx) : longint'(cx);
            fy += ((dy < 0) == pushes) ? -longint'(cy) : longint'(cy);
        endfunction

        // Multiply the magnitude, then divide or shift, truncating toward zero
        function longint scale(longint v, longint unsigned mul, longint unsigned div);
            longint unsigned m;
            m = mag_of(v) * mul;
            m = (div != 0) ? m / div : m >> FRAC;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function void note_node(node_t n);
            longint          rx, ry, vx, vy, fx, fy;
            longint unsigned mag2, lim2, one, keep;
            step_t           r;
            rx = n.pos_x; ry = n.pos_y; vx = n.vel_x; vy = n.vel_y;
            fx = 0; fy = 0;
            spring(rx, ry, n.first_x, n.first_y, fx, fy);
            spring(rx, ry, n.second_x, n.second_y, fx, fy);
            if (n.third_x != n.pos_x && n.third_y != n.pos_y)
                spring(rx, ry, n.third_x, n.third_y, fx, fy);
            if (n.fourth_x != n.pos_x && n.fourth_y != n.pos_y)
                spring(rx, ry, n.fourth_x, n.fourth_y, fx, fy);
            fx = sat(fx);
            fy = sat(fy - longint'(grav));
            vx = sat(vx + fx);
            vy = sat(vy + fy);
            mag2 = mag_of(vx) * mag_of(vx) + mag_of(vy) * mag_of(vy);
            lim2 = limit * limit;
            r.speed_clamped = (mag2 > lim2);
            if (r.speed_clamped) begin
                vx = scale(vx, limit, root(mag2));
                vy = scale(vy, limit, root(mag2));
            end
            one = 64'd1 << FRAC;
            keep = one - ((damp > one) ? one : damp);
            vx = scale(vx, keep, 0);
            vy = scale(vy, keep, 0);
            r.new_pos_x = 32'(rx + vx);
            r.new_pos_y = 32'(ry + vy);
            r.new_vel_x = 32'(vx);
            r.new_vel_y = 32'(vy);
            pending.push_back(r);
        endfunction

        function void check_step(step_t got);
            step_t e;
            if (pending.size() == 0) begin
                $error("result with no node pending");
                fails++;
                return;
            end
            e = pending.pop_front();
            if (got.new_pos_x !== e.new_pos_x) begin
                $error("new_pos_x expected %0d got %0d", e.new_pos_x, got.new_pos_x);
                fails++;
            end
            if (got.new_pos_y !== e.new_pos_y) begin
                $error("new_pos_y expected %0d got %0d", e.new_pos_y, got.new_pos_y);
                fails++;
            end
            if (got.new_vel_x !== e.new_vel_x) begin
                $error("new_vel_x expected %0d got %0d", e.new_vel_x, got.new_vel_x);
                fails++;
            end
            if (got.new_vel_y !== e.new_vel_y) begin
                $error("new_vel_y expected %0d got %0d", e.new_vel_y, got.new_vel_y);
                fails++;
            end
            if (got.speed_clamped !== e.speed_clamped) begin
                $error("speed_clamped expected %0b got %0b", e.speed_clamped,
                       got.speed_clamped);
                fails++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [31:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
    logic signed [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
    logic signed [31:0] third_x = '0, third_y = '0, fourth_x = '0, fourth_y = '0;
    logic               done;
    logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
    logic               speed_clamped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    step_scoreboard sb;

    cloth_node_spring_update #(.FRAC_BITS(FRAC)) uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Check every result transaction on the edge that ends its cycle
    always @(posedge clk)
    begin
        step_t got;
        if (rst_n && done) begin
            got.new_pos_x = new_pos_x;
            got.new_pos_y = new_pos_y;
            got.new_vel_x = new_vel_x;
            got.new_vel_y = new_vel_y;
            got.speed_clamped = speed_clamped;
            sb.check_step(got);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(21, 160);
    endfunction

    // Drive one node command and hold it until accepted
    task automatic send_node(node_t n, int gap);
        start    <= 1'b1;
        pos_x    <= n.pos_x;    pos_y    <= n.pos_y;
        vel_x    <= n.vel_x;    vel_y    <= n.vel_y;
        first_x  <= n.first_x;  first_y  <= n.first_y;
        second_x <= n.second_x; second_y <= n.second_y;
        third_x  <= n.third_x;  third_y  <= n.third_y;
        fourth_x <= n.fourth_x; fourth_y <= n.fourth_y;
        do @(posedge clk); while (busy);
        sb.note_node(n);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(cfg_index_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop start, then wait out every node in flight
    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] s, logic [31:0] r, logic [31:0] g,
                             logic [31:0] d, logic [31:0] l);
        write_reg(CFG_STIFFNESS, s);
        write_reg(CFG_REST_LENGTH, r);
        write_reg(CFG_GRAVITY, g);
        write_reg(CFG_DAMPING, d);
        write_reg(CFG_SPEED_LIMIT, l);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] c, int span);
        return c + $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Mostly cloth-like nodes near their neighbours, some wide-open noise
    function automatic node_t rand_node();
        node_t n;
        int    kind;
        kind = $urandom_range(0, 99);
        n.pos_x = $urandom; n.pos_y = $urandom; n.vel_x = $urandom; n.vel_y = $urandom;
        n.first_x = $urandom; n.first_y = $urandom; n.second_x = $urandom;
        n.second_y = $urandom; n.third_x = $urandom; n.third_y = $urandom;
        n.fourth_x = $urandom; n.fourth_y = $urandom;
        if (kind < 70) begin
            n.pos_x = near(0, 1 << 29);
            n.pos_y = near(0, 1 << 29);
            n.vel_x = near(0, (kind < 50) ? (1 << 22) : (1 << 25));
            n.vel_y = near(0, (kind < 50) ? (1 << 22) : (1 << 25));
            n.first_x  = near(n.pos_x, 1 << 25); n.first_y  = near(n.pos_y, 1 << 25);
            n.second_x = near(n.pos_x, 1 << 25); n.second_y = near(n.pos_y, 1 << 25);
            n.third_x  = near(n.pos_x, 1 << 25); n.third_y  = near(n.pos_y, 1 << 25);
            n.fourth_x = near(n.pos_x, 1 << 25); n.fourth_y = near(n.pos_y, 1 << 25);
            // mark missing or coincident neighbours now and then
            if ($urandom_range(0, 3) == 0) n.third_x = n.pos_x;
            if ($urandom_range(0, 3) == 0) n.third_y = n.pos_y;
            if ($urandom_range(0, 3) == 0) n.fourth_x = n.pos_x;
            if ($urandom_range(0, 3) == 0) n.fourth_y = n.pos_y;
            if ($urandom_range(0, 9) == 0) begin
                n.first_x = n.pos_x; n.first_y = n.pos_y;
            end
        end else if (kind < 85) begin
            n.vel_x = near(0, 1 << 24);
            n.vel_y = near(0, 1 << 24);
        end
        return n;
    endfunction

    function automatic node_t same_node(logic signed [31:0] p, logic signed [31:0] v,
                                        logic signed [31:0] q);
        node_t n;
        n.pos_x = p; n.pos_y = p; n.vel_x = v; n.vel_y = v;
        n.first_x = q; n.first_y = q; n.second_x = q; n.second_y = q;
        n.third_x = q; n.third_y = q; n.fourth_x = q; n.fourth_y = q;
        return n;
    endfunction

    task automatic directed_nodes();
        node_t n;
        logic signed [31:0] mx, mn;
        mx = 32'sh7fffffff;
        mn = 32'sh80000000;
        send_node(same_node(0, 0, 0), 0);              // every neighbour coincident
        send_node(same_node(mx, mx, mx), 1);
        send_node(same_node(mn, mn, mn), 0);
        send_node(same_node(mn, mx, mx), 2);           // offsets saturate
        send_node(same_node(mx, mn, mn), 0);
        send_node(same_node(0, mx, 32'sd1), 0);        // speed clamp
        send_node(same_node(0, mn, 32'sd1), 3);
        send_node(same_node(32'sd5 << 20, 0, 32'sd15 << 20), 0);
        send_node(same_node(32'sd5 << 20, 32'sd4 << 20, 32'sd5 << 20), 0);
        // third neighbour shares only x, fourth only y
        n = same_node(32'sd1 << 20, 0, 32'sd3 << 20);
        n.third_x = n.pos_x;
        n.fourth_y = n.pos_y;
        send_node(n, 1);
        n.third_x = 32'sd9 << 20;
        n.fourth_y = -(32'sd9 << 20);
        send_node(n, 0);
        n.first_x = n.pos_x + 1;
        n.first_y = n.pos_y;
        send_node(n, 0);
        for (int i = 0; i < 8; i++)
            send_node(rand_node(), pick_gap());
    endtask

    task automatic random_nodes(int count);
        for (int i = 0; i < count; i++)
            send_node(rand_node(), ($urandom_range(0, 5) == 0) ? 0 : pick_gap());
    endtask

    initial
    begin
        sb = new();
        sb.reset_regs();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_nodes();
        random_nodes(400);
        drain();

        write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h001fffff, 32'h7fffffff);
        directed_nodes();
        random_nodes(230);
        drain();

        write_all(0, 0, 0, 0, 0);
        directed_nodes();
        random_nodes(230);
        drain();

        write_all(32'd1 << 20, 32'd1 << 20, 32'd100, 32'd1 << 20, 32'd1 << 24);
        random_nodes(230);
        drain();

        write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        random_nodes(230);
        drain();

        write_all($urandom_range(0, 1 << 21), $urandom_range(0, 1 << 25),
                  $urandom_range(0, 1 << 14), $urandom_range(0, 1 << 16),
                  $urandom_range(0, 1 << 24));
        random_nodes(230);
        drain();

        if (sb.fails == 0)
            $display("tb_cloth_node_spring_update passed");
        else
            $display("tb_cloth_node_spring_update failed");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("tb_cloth_node_spring_update failed");
        $finish;
    end

endmodule

[files.f]
design/cnsu_pkg.sv
design/cnsu_isqrt.sv
design/cnsu_div.sv
design/cnsu_spring.sv
design/cnsu_vel.sv
design/cloth_node_spring_update.sv
verif/tb_cloth_node_spring_update.sv
